// ----- rtl/core/rgb_knob_editor_with_pickup_macros.svh -----
// Assertion macros for the RGB knob editor.
`ifndef RGB_KNOB_EDITOR_WITH_PICKUP_MACROS_SVH
`define RGB_KNOB_EDITOR_WITH_PICKUP_MACROS_SVH

`ifndef SYNTHESIS
`define RKE_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgb_knob_editor_with_pickup: property failed");
`define RKE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgb_knob_editor_with_pickup: property failed");
`else
`define RKE_ASSERT_IMPLIES(label, ante, cons)
`define RKE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/rke_pkg.sv -----
// Shared types, constants and the divide-by-full-scale function of the knob editor.
package rke_pkg;

  localparam int unsigned LEVEL_W   = 10;
  localparam int unsigned BAR_W     = 7;
  localparam int unsigned COL_W     = 6;
  localparam int unsigned CHAN_W    = 2;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned HOLDOFF_W = 16;
  localparam int unsigned PROD_W    = 2 * LEVEL_W;
  localparam int unsigned NUM_CHANNELS = 3;

  localparam logic [LEVEL_W-1:0]   FULL_SCALE    = 10'd1023;
  localparam logic [LEVEL_W-1:0]   BAR_LENGTH    = 10'd75;
  localparam logic [LEVEL_W-1:0]   RED_BLUE_MAX  = 10'd31;
  localparam logic [LEVEL_W-1:0]   GREEN_MAX     = 10'd63;
  localparam logic [LEVEL_W-1:0]   RESET_LEVEL   = 10'd256;
  localparam logic [LEVEL_W-1:0]   RESET_WINDOW  = 10'd50;
  localparam logic [HOLDOFF_W-1:0] RESET_HOLDOFF = 16'd200;
  localparam logic [BAR_W-1:0]     BAR_CAP       = 7'd127;
  localparam logic [COL_W-1:0]     GREEN_CAP     = 6'd63;
  localparam logic [COL_W-1:0]     RED_BLUE_CAP  = 6'd31;
  localparam logic [CHAN_W-1:0]    FIRST_CHAN    = 2'd0;
  localparam logic [CHAN_W-1:0]    GREEN_CHAN    = 2'd1;
  localparam logic [CHAN_W-1:0]    LAST_CHAN     = CHAN_W'(NUM_CHANNELS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOGGLE,
    ST_SELECT,
    ST_PICKUP,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    OP_DRIVE,
    OP_BAR,
    OP_COLOUR
  } op_kind_e;

  typedef enum logic {
    REG_PICKUP_WINDOW = 1'b0,
    REG_MODE_HOLDOFF  = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic                capture;
    logic                toggle;
    logic                select;
    logic                pickup;
    logic                load_work;
    logic                issue;
    logic                writeback;
    logic                load_out;
    op_kind_e            kind;
    logic [CHAN_W-1:0]   chan;
  } dp_cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]   pickup_window;
    logic [HOLDOFF_W-1:0] mode_holdoff_ms;
  } cfg_t;

  // floor(x / 1023): x = 1024a + b gives x = 1023a + (a + b), then correct by up to two
  function automatic logic [LEVEL_W-1:0] div_full_scale(input logic [PROD_W-1:0] x);
    logic [LEVEL_W-1:0] hi_part;
    logic [LEVEL_W:0]   rem_sum;
    logic [LEVEL_W:0]   quot;
    hi_part = x[PROD_W-1:LEVEL_W];
    rem_sum = {1'b0, hi_part} + {1'b0, x[LEVEL_W-1:0]};
    quot    = {1'b0, hi_part};
    if (rem_sum >= {FULL_SCALE, 1'b0}) begin
      quot = quot + (LEVEL_W+1)'(2);
    end else if (rem_sum >= {1'b0, FULL_SCALE}) begin
      quot = quot + (LEVEL_W+1)'(1);
    end
    return quot[LEVEL_W] ? {LEVEL_W{1'b1}} : quot[LEVEL_W-1:0];
  endfunction

endpackage

// ----- rtl/core/rke_cfg_regs.sv -----
// Configuration register file with its APB-style access port.
module rke_cfg_regs import rke_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        reg_sel,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic       wr_en;
  reg_index_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_index_e'(reg_sel);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_PICKUP_WINDOW: cfg_d.pickup_window   = pwdata[LEVEL_W-1:0];
        REG_MODE_HOLDOFF:  cfg_d.mode_holdoff_ms = pwdata[HOLDOFF_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PICKUP_WINDOW: prdata = 32'(cfg_q.pickup_window);
      REG_MODE_HOLDOFF:  prdata = 32'(cfg_q.mode_holdoff_ms);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pickup_window   <= RESET_WINDOW;
      cfg_q.mode_holdoff_ms <= RESET_HOLDOFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/core/rke_ctrl.sv -----
// Sequencer for one request: state update steps, scale operations and result hand-off.
module rke_ctrl import rke_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e       state_q, state_d;
  op_kind_e          kind_q, kind_d;
  logic [CHAN_W-1:0] chan_q, chan_d;
  logic              out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    chan_d      = chan_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.kind  = kind_q;
    cmd_o.chan  = chan_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_TOGGLE;
        end
      end
      ST_TOGGLE: begin
        cmd_o.toggle = 1'b1;
        state_d      = ST_SELECT;
      end
      ST_SELECT: begin
        cmd_o.select = 1'b1;
        state_d      = ST_PICKUP;
      end
      ST_PICKUP: begin
        cmd_o.pickup = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load_work = 1'b1;
        kind_d          = OP_DRIVE;
        chan_d          = FIRST_CHAN;
        state_d         = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.issue = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.writeback = 1'b1;
        state_d         = ST_MUL;
        case (kind_q)
          OP_DRIVE: kind_d = OP_BAR;
          OP_BAR:   kind_d = OP_COLOUR;
          default: begin
            kind_d = OP_DRIVE;
            if (chan_q == LAST_CHAN) begin
              state_d = ST_DONE;
            end else begin
              chan_d = chan_q + CHAN_W'(1);
            end
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= OP_DRIVE;
      chan_q      <= FIRST_CHAN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/rke_datapath.sv -----
// Editor state, shared multiply and divide-by-full-scale unit, and result registers.
module rke_datapath import rke_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  cfg_t                 cfg_i,
  input  logic [LEVEL_W-1:0]   knob_sample_i,
  input  logic                 sample_valid_i,
  input  logic                 mode_press_i,
  input  logic                 select_press_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  output logic [LEVEL_W-1:0]   red_drive_o,
  output logic [LEVEL_W-1:0]   green_drive_o,
  output logic [LEVEL_W-1:0]   blue_drive_o,
  output logic [BAR_W-1:0]     red_bar_o,
  output logic [BAR_W-1:0]     green_bar_o,
  output logic [BAR_W-1:0]     blue_bar_o,
  output logic [15:0]          preview_rgb565_o,
  output logic                 edit_mode_o,
  output logic [CHAN_W-1:0]    selected_channel_o,
  output logic [LEVEL_W-1:0]   knob_level_o
);

  logic [LEVEL_W-1:0] knob_q;
  logic               valid_q;
  logic               mpress_q;
  logic               spress_q;
  logic [TIME_W-1:0]  now_q;

  logic               mode_q;
  logic [CHAN_W-1:0]  chan_q;
  logic [LEVEL_W-1:0] level_q [NUM_CHANNELS];
  logic [LEVEL_W-1:0] held_q;
  logic               tracking_q;
  logic [TIME_W-1:0]  last_toggle_q;

  logic [LEVEL_W-1:0] lvl_sh_q [NUM_CHANNELS];
  logic [LEVEL_W-1:0] drv_sh_q [NUM_CHANNELS];
  logic [BAR_W-1:0]   bar_sh_q [NUM_CHANNELS];
  logic [COL_W-1:0]   col_sh_q [NUM_CHANNELS];
  logic [LEVEL_W-1:0] cur_drive_q;
  logic [BAR_W-1:0]   cur_bar_q;
  logic [PROD_W-1:0]  prod_q;

  logic [TIME_W-1:0]  elapsed;
  logic               toggle_hit;
  logic [CHAN_W-1:0]  next_chan;
  logic [LEVEL_W-1:0] stored;
  logic [LEVEL_W-1:0] win_lo;
  logic [LEVEL_W:0]   win_hi;
  logic               in_window;
  logic [LEVEL_W-1:0] op_a;
  logic [LEVEL_W-1:0] op_b;
  logic [PROD_W-1:0]  prod_d;
  logic [LEVEL_W-1:0] quot;
  logic [BAR_W-1:0]   bar_sat;
  logic [COL_W-1:0]   col_cap;
  logic [COL_W-1:0]   col_sat;

  assign elapsed    = now_q - last_toggle_q;
  assign toggle_hit = mpress_q && (elapsed > TIME_W'(cfg_i.mode_holdoff_ms));
  assign next_chan  = (chan_q == LAST_CHAN) ? FIRST_CHAN : chan_q + CHAN_W'(1);

  assign stored    = level_q[chan_q];
  assign win_lo    = (stored > cfg_i.pickup_window) ? stored - cfg_i.pickup_window : '0;
  assign win_hi    = {1'b0, stored} + {1'b0, cfg_i.pickup_window};
  assign in_window = (held_q >= win_lo) && ({1'b0, held_q} <= win_hi);

  assign op_a = (cmd_i.kind == OP_DRIVE) ? lvl_sh_q[0] : cur_drive_q;

  always_comb begin
    case (cmd_i.kind)
      OP_DRIVE:  op_b = mode_q ? FULL_SCALE : held_q;
      OP_BAR:    op_b = BAR_LENGTH;
      OP_COLOUR: op_b = (cmd_i.chan == GREEN_CHAN) ? GREEN_MAX : RED_BLUE_MAX;
      default:   op_b = '0;
    endcase
  end

  assign prod_d  = PROD_W'(op_a) * PROD_W'(op_b);
  assign quot    = div_full_scale(prod_q);
  assign bar_sat = (quot > LEVEL_W'(BAR_CAP)) ? BAR_CAP : quot[BAR_W-1:0];
  assign col_cap = (cmd_i.chan == GREEN_CHAN) ? GREEN_CAP : RED_BLUE_CAP;
  assign col_sat = (quot > LEVEL_W'(col_cap)) ? col_cap : quot[COL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= 1'b0;
      chan_q        <= FIRST_CHAN;
      held_q        <= '0;
      tracking_q    <= 1'b1;
      last_toggle_q <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        level_q[i] <= RESET_LEVEL;
      end
    end else begin
      if (cmd_i.toggle) begin
        if (toggle_hit) begin
          mode_q        <= !mode_q;
          last_toggle_q <= now_q;
          tracking_q    <= 1'b1;
        end
        if (valid_q) begin
          held_q <= knob_q;
        end
      end
      if (cmd_i.select && mode_q && spress_q) begin
        if (tracking_q) begin
          level_q[chan_q] <= held_q;
        end
        chan_q     <= next_chan;
        tracking_q <= 1'b0;
      end
      if (cmd_i.pickup && mode_q) begin
        if (!tracking_q && in_window) begin
          tracking_q <= 1'b1;
        end
        if (tracking_q || in_window) begin
          level_q[chan_q] <= held_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      knob_q   <= knob_sample_i;
      valid_q  <= sample_valid_i;
      mpress_q <= mode_press_i;
      spress_q <= select_press_i;
      now_q    <= now_ms_i;
    end
    if (cmd_i.load_work) begin
      lvl_sh_q <= level_q;
    end
    if (cmd_i.issue) begin
      prod_q <= prod_d;
    end
    if (cmd_i.writeback) begin
      case (cmd_i.kind)
        OP_DRIVE: cur_drive_q <= quot;
        OP_BAR:   cur_bar_q   <= bar_sat;
        default: begin
          // advance all channel lines by one place
          for (int i = 0; i < NUM_CHANNELS - 1; i++) begin
            lvl_sh_q[i] <= lvl_sh_q[i+1];
            drv_sh_q[i] <= drv_sh_q[i+1];
            bar_sh_q[i] <= bar_sh_q[i+1];
            col_sh_q[i] <= col_sh_q[i+1];
          end
          lvl_sh_q[NUM_CHANNELS-1] <= lvl_sh_q[0];
          drv_sh_q[NUM_CHANNELS-1] <= cur_drive_q;
          bar_sh_q[NUM_CHANNELS-1] <= cur_bar_q;
          col_sh_q[NUM_CHANNELS-1] <= col_sat;
        end
      endcase
    end
    if (cmd_i.load_out) begin
      red_drive_o        <= drv_sh_q[0];
      green_drive_o      <= drv_sh_q[1];
      blue_drive_o       <= drv_sh_q[2];
      red_bar_o          <= bar_sh_q[0];
      green_bar_o        <= bar_sh_q[1];
      blue_bar_o         <= bar_sh_q[2];
      preview_rgb565_o   <= {col_sh_q[0][4:0], col_sh_q[1], col_sh_q[2][4:0]};
      edit_mode_o        <= mode_q;
      selected_channel_o <= chan_q;
      knob_level_o       <= held_q;
    end
  end

endmodule

// ----- rtl/core/rgb_knob_editor_with_pickup.sv -----
// RGB knob editor with soft pickup. After a request is accepted, the toggle, select
// and pickup steps apply the mode toggle with its hold-off, the knob capture, and the
// channel select and pickup edit; a load step copies the channel levels into the work
// line; then nine scale operations (drive, bar length and colour part for each
// channel) pass through one shared 10x10 multiplier and a divide-by-1023 stage, as a
// multiply step and a divide step each, and the result moves into the output register
// once the previous result is no longer stalled. A new request is taken as soon as
// the result sits in that register, even while it is still stalled.
// Configuration: pickup_window at byte address 0, mode_holdoff_ms at 4.
`include "rgb_knob_editor_with_pickup_macros.svh"

module rgb_knob_editor_with_pickup import rke_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [LEVEL_W-1:0]   knob_sample_i,
  input  logic                 sample_valid_i,
  input  logic                 mode_press_i,
  input  logic                 select_press_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LEVEL_W-1:0]   red_drive_o,
  output logic [LEVEL_W-1:0]   green_drive_o,
  output logic [LEVEL_W-1:0]   blue_drive_o,
  output logic [BAR_W-1:0]     red_bar_o,
  output logic [BAR_W-1:0]     green_bar_o,
  output logic [BAR_W-1:0]     blue_bar_o,
  output logic [15:0]          preview_rgb565_o,
  output logic                 edit_mode_o,
  output logic [CHAN_W-1:0]    selected_channel_o,
  output logic [LEVEL_W-1:0]   knob_level_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  dp_cmd_t cmd;
  cfg_t    cfg;

  rke_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .reg_sel (paddr[2]),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rke_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  rke_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_i              (cfg),
    .knob_sample_i      (knob_sample_i),
    .sample_valid_i     (sample_valid_i),
    .mode_press_i       (mode_press_i),
    .select_press_i     (select_press_i),
    .now_ms_i           (now_ms_i),
    .red_drive_o        (red_drive_o),
    .green_drive_o      (green_drive_o),
    .blue_drive_o       (blue_drive_o),
    .red_bar_o          (red_bar_o),
    .green_bar_o        (green_bar_o),
    .blue_bar_o         (blue_bar_o),
    .preview_rgb565_o   (preview_rgb565_o),
    .edit_mode_o        (edit_mode_o),
    .selected_channel_o (selected_channel_o),
    .knob_level_o       (knob_level_o)
  );

  `RKE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `RKE_ASSERT_IMPLIES(a_channel_in_range, out_valid_o, selected_channel_o <= LAST_CHAN)
  `RKE_ASSERT_IMPLIES(a_red_bar_in_range, out_valid_o, LEVEL_W'(red_bar_o) <= BAR_LENGTH)
  `RKE_ASSERT_IMPLIES(a_green_bar_in_range, out_valid_o, LEVEL_W'(green_bar_o) <= BAR_LENGTH)
  `RKE_ASSERT_IMPLIES(a_blue_bar_in_range, out_valid_o, LEVEL_W'(blue_bar_o) <= BAR_LENGTH)

endmodule
